@@ hw/rtl/dvrt_pkg.sv @@
// Shared types, constants and codes for the distance-vector route table.
// No dependencies; every other file of the block but dvrt_ram imports this package.
`timescale 1ns / 1ps

package dvrt_pkg;

    // Table geometry: ids are 5 bits, so at most 32 entries are addressable
    localparam int NODE_COUNT  = 32;
    localparam int ID_W        = 5;
    localparam int ID_SPACE    = 1 << ID_W;
    localparam int TABLE_DEPTH = (NODE_COUNT < ID_SPACE) ? NODE_COUNT : ID_SPACE;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int DIST_W = 5;
    localparam int AGE_W  = 8;
    localparam int TICK_W = 8;
    localparam int MASK_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIST_W-1:0] UNREACHABLE = DIST_W'(16);
    localparam logic [DIST_W-1:0] DIST_SELF   = DIST_W'(0);
    localparam logic [DIST_W-1:0] DIST_NEIGH  = DIST_W'(1);
    localparam logic [AGE_W-1:0]  AGE_MAX     = '1;

    // Register reset values
    localparam logic [ID_W-1:0]   OWN_ID_RST   = '0;
    localparam logic [MASK_W-1:0] NEIGH_RST    = '0;
    localparam logic [TICK_W-1:0] INTERVAL_RST = TICK_W'(5);
    localparam logic [AGE_W-1:0]  TIMEOUT_RST  = AGE_W'(15);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

    // Request operations
    localparam logic [1:0] OP_ADVERT  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_REBUILD = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_ROUTE   = 2'd2;
    localparam logic [1:0] KIND_REBUILD = 2'd3;

    // Route change codes
    localparam logic [1:0] CHANGE_NONE   = 2'd0;
    localparam logic [1:0] CHANGE_LEARN  = 2'd1;
    localparam logic [1:0] CHANGE_SAME   = 2'd2;
    localparam logic [1:0] CHANGE_BETTER = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ID_W-1:0]   sender_id;
        logic [ID_W-1:0]   dest_id;
        logic [DIST_W-1:0] advertised_distance;
    } req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        change;
        logic [ID_W-1:0]   route_dest;
        logic [ID_W-1:0]   route_next_hop;
        logic [DIST_W-1:0] route_distance;
        logic              aged_any;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]   own_id;
        logic [MASK_W-1:0] neighbor_mask;
        logic [TICK_W-1:0] advert_period;
        logic [AGE_W-1:0]  route_timeout;
    } cfg_t;

    // One table entry as held in memory
    typedef struct packed {
        logic [ID_W-1:0]   next_hop;
        logic [DIST_W-1:0] distance;
        logic [AGE_W-1:0]  age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Table memory port controls
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_ctl_t;

endpackage

@@ hw/rtl/dvrt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/dvrt_cfg_regs.sv @@
// Configuration register file of the route table.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_cfg_regs
    import dvrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and take the low bits of the write data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_OWN_ID:   cfg_next.own_id          = cfg_data[ID_W-1:0];
                CFG_NEIGH:    cfg_next.neighbor_mask   = cfg_data[MASK_W-1:0];
                CFG_INTERVAL: cfg_next.advert_period   = cfg_data[TICK_W-1:0];
                CFG_TIMEOUT:  cfg_next.route_timeout   = cfg_data[AGE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_id          <= OWN_ID_RST;
            cfg_reg.neighbor_mask   <= NEIGH_RST;
            cfg_reg.advert_period   <= INTERVAL_RST;
            cfg_reg.route_timeout   <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/dvrt_engine.sv @@
// Route table sequencer: valid bits, tick counter and the read-modify-write
// passes over the table memory. Depends on dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_engine
    import dvrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     req_accept,
    input  req_t     req,
    output logic     idle,
    input  logic     slot_free,
    output logic     res_load,
    output result_t  res,
    output mem_ctl_t mem,
    input  entry_t   rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV_WB,
        ST_AGE,
        ST_TICK_DECIDE,
        ST_EMIT,
        ST_REBUILD,
        ST_RESULT
    } state_t;

    localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(TABLE_DEPTH - 1);

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TICK_W-1:0]      tick_count_reg, tick_count_next;
    logic                   aged_reg, aged_next;
    logic [ID_W-1:0]        sender_reg, sender_next;
    logic [ID_W-1:0]        dest_reg, dest_next;
    logic [DIST_W-1:0]      nd_reg, nd_next;
    logic                   in_range_reg, in_range_next;
    logic [1:0]             res_kind_reg, res_kind_next;

    logic [ADDR_W-1:0]      dest_addr;
    logic [ADDR_W-1:0]      idx_inc;
    logic                   is_own;
    logic                   above_any;
    logic [TABLE_DEPTH-1:0] rebuild_mask;

    // Advert update terms
    logic                   adv_valid;
    logic                   adv_write;
    logic                   adv_keep_valid;
    logic [1:0]             adv_change;
    entry_t                 adv_entry;

    // Aging terms
    logic                   age_apply;
    logic                   age_timed;
    entry_t                 age_entry;

    // Tick counter terms
    logic [TICK_W-1:0]      tick_inc;
    logic [TICK_W-1:0]      interval;
    logic                   due;

    assign dest_addr = dest_reg[ADDR_W-1:0];
    assign idx_inc   = idx_reg + ADDR_W'(1);
    assign is_own    = (ID_W'(idx_reg) == cfg.own_id);

    // Look for any valid entry above the current one
    always_comb
    begin
        above_any = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (valid_reg[j] && (ADDR_W'(j) > idx_reg))
            begin
                above_any = 1'b1;
            end
        end
    end

    // Valid set after a rebuild: own id plus every neighbor
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rebuild_mask[i] = (ID_W'(i) == cfg.own_id) || cfg.neighbor_mask[i];
        end
    end

    // Decide the advert update: learn, follow the current hop, or take a shorter path
    always_comb
    begin
        adv_valid      = in_range_reg && valid_reg[dest_addr];
        adv_write      = 1'b0;
        adv_keep_valid = adv_valid;
        adv_change     = CHANGE_NONE;
        adv_entry      = rd_data;
        if (!adv_valid)
        begin
            if (in_range_reg && (nd_reg < UNREACHABLE))
            begin
                adv_write          = 1'b1;
                adv_keep_valid     = 1'b1;
                adv_change         = CHANGE_LEARN;
                adv_entry.next_hop = sender_reg;
                adv_entry.distance = nd_reg;
                adv_entry.age      = '0;
            end
        end
        else if (rd_data.next_hop == sender_reg)
        begin
            adv_write          = 1'b1;
            adv_entry.distance = nd_reg;
            adv_entry.age      = '0;
            if (rd_data.distance != nd_reg)
            begin
                adv_change = CHANGE_SAME;
            end
        end
        else if (nd_reg < rd_data.distance)
        begin
            adv_write          = 1'b1;
            adv_change         = CHANGE_BETTER;
            adv_entry.next_hop = sender_reg;
            adv_entry.distance = nd_reg;
            adv_entry.age      = '0;
        end
    end

    // Age one entry: saturate the age, mark it unreachable on timeout
    always_comb
    begin
        age_apply = valid_reg[idx_reg] && !is_own;
        age_entry = rd_data;
        if (rd_data.age != AGE_MAX)
        begin
            age_entry.age = rd_data.age + AGE_W'(1);
        end
        age_timed = (age_entry.age >= cfg.route_timeout) && (rd_data.distance < UNREACHABLE);
        if (age_timed)
        begin
            age_entry.distance = UNREACHABLE;
        end
    end

    // Advance the tick counter and check for an advertisement
    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign interval = (cfg.advert_period == '0) ? TICK_W'(1) : cfg.advert_period;
    assign due      = (tick_inc >= interval);

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        tick_count_next = tick_count_reg;
        aged_next       = aged_reg;
        sender_next     = sender_reg;
        dest_next       = dest_reg;
        nd_next         = nd_reg;
        in_range_next   = in_range_reg;
        res_kind_next   = res_kind_reg;
        mem             = '0;
        res             = '0;
        res_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (req.operation)
                        OP_ADVERT:
                        begin
                            sender_next   = req.sender_id;
                            dest_next     = req.dest_id;
                            nd_next       = (req.advertised_distance >= UNREACHABLE) ?
                                            UNREACHABLE : req.advertised_distance + DIST_W'(1);
                            in_range_next = (int'(req.dest_id) < NODE_COUNT);
                            mem.rd_en     = (int'(req.dest_id) < NODE_COUNT);
                            mem.rd_addr   = req.dest_id[ADDR_W-1:0];
                            state_next    = ST_ADV_WB;
                        end
                        OP_TICK:
                        begin
                            mem.rd_en   = 1'b1;
                            mem.rd_addr = '0;
                            idx_next    = '0;
                            aged_next   = 1'b0;
                            state_next  = ST_AGE;
                        end
                        OP_REBUILD:
                        begin
                            valid_next      = rebuild_mask;
                            tick_count_next = '0;
                            idx_next        = '0;
                            aged_next       = 1'b0;
                            state_next      = ST_REBUILD;
                        end
                        default:
                        begin
                            // drop the unknown operation, no result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADV_WB:
            begin
                if (slot_free)
                begin
                    mem.wr_en   = adv_write;
                    mem.wr_addr = dest_addr;
                    mem.wr_data = adv_entry;
                    if (adv_write)
                    begin
                        valid_next[dest_addr] = 1'b1;
                    end
                    res_load           = 1'b1;
                    res.kind           = KIND_ENTRY;
                    res.change         = adv_change;
                    res.route_dest     = dest_reg;
                    res.route_next_hop = adv_keep_valid ? adv_entry.next_hop : '0;
                    res.route_distance = adv_keep_valid ? adv_entry.distance : UNREACHABLE;
                    res.last           = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_AGE:
            begin
                mem.wr_en   = age_apply;
                mem.wr_addr = idx_reg;
                mem.wr_data = age_entry;
                if (age_apply && age_timed)
                begin
                    aged_next = 1'b1;
                end
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_TICK_DECIDE;
                end
                else
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = idx_inc;
                    idx_next    = idx_inc;
                end
            end

            ST_TICK_DECIDE:
            begin
                tick_count_next = due ? '0 : tick_inc;
                if (due && (valid_reg != '0))
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = '0;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    res_kind_next = KIND_TICK;
                    state_next    = ST_RESULT;
                end
            end

            ST_EMIT:
            begin
                if (!valid_reg[idx_reg])
                begin
                    // skip an empty entry
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = idx_inc;
                        idx_next    = idx_inc;
                    end
                end
                else if (slot_free)
                begin
                    res_load           = 1'b1;
                    res.kind           = KIND_ROUTE;
                    res.route_dest     = ID_W'(idx_reg);
                    res.route_next_hop = rd_data.next_hop;
                    res.route_distance = rd_data.distance;
                    res.aged_any       = aged_reg;
                    res.last           = !above_any;
                    if (!above_any || (idx_reg == IDX_LAST))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = idx_inc;
                        idx_next    = idx_inc;
                    end
                end
            end

            ST_REBUILD:
            begin
                // install every entry; only those marked valid are ever used
                mem.wr_en            = 1'b1;
                mem.wr_addr          = idx_reg;
                mem.wr_data.next_hop = ID_W'(idx_reg);
                mem.wr_data.distance = is_own ? DIST_SELF : DIST_NEIGH;
                mem.wr_data.age      = '0;
                if (idx_reg == IDX_LAST)
                begin
                    res_kind_next = KIND_REBUILD;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_RESULT:
            begin
                if (slot_free)
                begin
                    res_load     = 1'b1;
                    res.kind     = res_kind_reg;
                    res.aged_any = aged_reg;
                    res.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters and the captured request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            tick_count_reg <= '0;
            aged_reg       <= 1'b0;
            res_kind_reg   <= KIND_TICK;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            tick_count_reg <= tick_count_next;
            aged_reg       <= aged_next;
            res_kind_reg   <= res_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sender_reg   <= sender_next;
        dest_reg     <= dest_next;
        nd_reg       <= nd_next;
        in_range_reg <= in_range_next;
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

@@ hw/rtl/distance_vector_route_table.sv @@
// Distance-vector route table with one result register on the output side.
// An advertised-entry request reads the table at acceptance, then does the
// update and write-back in ST_ADV_WB once the output register can take its
// result. A tick runs an aging pass over the table, one entry a cycle
// through the single table read port, then a decision state and a result
// state. When an advertisement is due, an emission pass from id 0 up to the
// last valid entry replaces the result state and waits whenever the output
// stalls; a rebuild writes the table, one entry write a cycle, then gives
// its result. Valid bits sit in flip-flops and clear at reset, so no
// clearing pass follows reset. A new request is taken whenever the
// sequencer is idle, even while a finished result still waits in the
// output register.
// Depends on dvrt_pkg, dvrt_cfg_regs, dvrt_engine, dvrt_ram.
`timescale 1ns / 1ps

module distance_vector_route_table
    import dvrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  req_t                  in_req,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               out_result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    logic     idle;
    logic     req_accept;
    logic     slot_free;
    logic     res_load;
    result_t  res;
    mem_ctl_t mem;
    entry_t   rd_data;

    logic     out_valid_reg, out_valid_next;
    result_t  out_result_reg, out_result_next;

    dvrt_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    dvrt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_accept (req_accept),
        .req        (in_req),
        .idle       (idle),
        .slot_free  (slot_free),
        .res_load   (res_load),
        .res        (res),
        .mem        (mem),
        .rd_data    (rd_data)
    );

    dvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    // Take a request only while the sequencer is idle
    assign in_stall   = !idle;
    assign req_accept = in_valid && idle;

    // Output register: load when empty or being drained
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (res_load)
        begin
            out_valid_next  = 1'b1;
            out_result_next = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

@@ hw/rtl/dvrt_checker.sv @@
// Port-level checks of the route table, bound to the top level.
// Depends on dvrt_pkg and distance_vector_route_table.
`timescale 1ns / 1ps

module dvrt_checker
    import dvrt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input req_t    in_req,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_result
);

    // A stalled result holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_result)))
    else $error("stalled result changed");

    // An accepted advert keeps the block busy for its write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_req.operation == OP_ADVERT)) |=> in_stall)
    else $error("advert request did not occupy the table");

    // Only entry results report a route change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_result.kind == KIND_ENTRY) || (out_result.change == CHANGE_NONE)))
    else $error("change reported on a non-entry result");

    // Distances never exceed the unreachable mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_result.route_distance <= UNREACHABLE))
    else $error("route distance beyond unreachable");

endmodule

bind distance_vector_route_table dvrt_checker u_checker (.*);

@@ bench/distance_vector_route_table_check.sv @@
// Route table checker: follows requests, register writes and results on the ports,
// keeps its own copy of the table and compares every result in order.
// Depends on dvrt_pkg for the request, result and code definitions.
`timescale 1ns / 1ps

module distance_vector_route_table_check
    import dvrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  req_t                  in_req,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  result_t               out_result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    // Register copies
    logic [ID_W-1:0]   self_id;
    logic [MASK_W-1:0] neighbors;
    logic [TICK_W-1:0] advert_interval;
    logic [AGE_W-1:0]  route_timeout;

    // Table copy
    logic              route_known [TABLE_DEPTH];
    logic [ID_W-1:0]   route_via   [TABLE_DEPTH];
    logic [DIST_W-1:0] route_hops  [TABLE_DEPTH];
    logic [AGE_W-1:0]  route_age   [TABLE_DEPTH];
    logic [TICK_W-1:0] ticks_since_advert;

    result_t awaited_results[$];

    function automatic result_t route_result(input logic [1:0] kind,
                                             input logic [1:0] change,
                                             input logic [ID_W-1:0] dest,
                                             input logic [ID_W-1:0] hop,
                                             input logic [DIST_W-1:0] hops,
                                             input logic aged,
                                             input logic last);
        result_t r;
        r.kind           = kind;
        r.change         = change;
        r.route_dest     = dest;
        r.route_next_hop = hop;
        r.route_distance = hops;
        r.aged_any       = aged;
        r.last           = last;
        return r;
    endfunction

    // Append one result to the awaited list
    task automatic queue_result(input result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // Apply one accepted request to the table copy and queue the results it causes
    task automatic update_routes(input req_t r);
        int unsigned       d;
        logic [DIST_W-1:0] nd;
        logic [1:0]        change;
        logic              aged;
        bit                due;
        int                listed;
        int                sent;
        case (r.operation)
            OP_ADVERT:
            begin
                d  = 32'(r.dest_id);
                nd = (r.advertised_distance >= UNREACHABLE) ? UNREACHABLE
                                                            : r.advertised_distance + DIST_W'(1);
                change = CHANGE_NONE;
                if (!route_known[d])
                begin
                    // learn only a reachable route
                    if (nd < UNREACHABLE)
                    begin
                        route_known[d] = 1'b1;
                        route_via[d]   = r.sender_id;
                        route_hops[d]  = nd;
                        route_age[d]   = '0;
                        change         = CHANGE_LEARN;
                    end
                end
                else if (route_via[d] == r.sender_id)
                begin
                    // follow the current next hop, whatever it says
                    if (route_hops[d] != nd)
                    begin
                        route_hops[d] = nd;
                        change        = CHANGE_SAME;
                    end
                    route_age[d] = '0;
                end
                else if (nd < route_hops[d])
                begin
                    route_via[d]  = r.sender_id;
                    route_hops[d] = nd;
                    route_age[d]  = '0;
                    change        = CHANGE_BETTER;
                end
                if (route_known[d])
                    queue_result(route_result(KIND_ENTRY, change, r.dest_id,
                                              route_via[d], route_hops[d],
                                              1'b0, 1'b1));
                else
                    queue_result(route_result(KIND_ENTRY, change, r.dest_id,
                                              '0, UNREACHABLE, 1'b0, 1'b1));
            end
            OP_TICK:
            begin
                // age every route but our own, expire the stale ones
                aged = 1'b0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (route_known[i] && i != self_id)
                    begin
                        if (route_age[i] != AGE_MAX)
                            route_age[i] = route_age[i] + AGE_W'(1);
                        if (route_age[i] >= route_timeout && route_hops[i] < UNREACHABLE)
                        begin
                            route_hops[i] = UNREACHABLE;
                            aged          = 1'b1;
                        end
                    end
                end
                ticks_since_advert = ticks_since_advert + TICK_W'(1);
                due = ticks_since_advert >= ((advert_interval == '0) ? 1 : advert_interval);
                if (due)
                    ticks_since_advert = '0;
                listed = 0;
                if (due)
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (route_known[i])
                            listed++;
                end
                if (listed == 0)
                    queue_result(route_result(KIND_TICK, CHANGE_NONE, '0, '0, '0,
                                              aged, 1'b1));
                else
                begin
                    // advertise known routes in ascending id order
                    sent = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (route_known[i])
                        begin
                            sent++;
                            queue_result(route_result(KIND_ROUTE, CHANGE_NONE,
                                                      ID_W'(i), route_via[i],
                                                      route_hops[i], aged,
                                                      sent == listed));
                        end
                    end
                end
            end
            OP_REBUILD:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    route_known[i] = 1'b0;
                    route_via[i]   = '0;
                    route_hops[i]  = '0;
                    route_age[i]   = '0;
                end
                ticks_since_advert = '0;
                // install direct neighbors, then our own id
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (neighbors[i] && i != self_id)
                    begin
                        route_known[i] = 1'b1;
                        route_via[i]   = ID_W'(i);
                        route_hops[i]  = DIST_NEIGH;
                    end
                end
                route_known[self_id] = 1'b1;
                route_via[self_id]   = self_id;
                route_hops[self_id]  = DIST_SELF;
                route_age[self_id]   = '0;
                queue_result(route_result(KIND_REBUILD, CHANGE_NONE, '0, '0, '0,
                                          1'b0, 1'b1));
            end
            default:
                ;   // unused operation: dropped without a result
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare an accepted result with the oldest one awaited
    task automatic match_result(input result_t got);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: result %h arrived with none awaited", $time, got);
            mismatches++;
        end
        else
        begin
            want = awaited_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(got.kind));
            check_field("change", 8'(want.change), 8'(got.change));
            check_field("route_dest", 8'(want.route_dest), 8'(got.route_dest));
            check_field("route_next_hop", 8'(want.route_next_hop), 8'(got.route_next_hop));
            check_field("route_distance", 8'(want.route_distance), 8'(got.route_distance));
            check_field("aged_any", 8'(want.aged_any), 8'(got.aged_any));
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id            = OWN_ID_RST;
            neighbors          = NEIGH_RST;
            advert_interval    = INTERVAL_RST;
            route_timeout      = TIMEOUT_RST;
            ticks_since_advert = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                route_known[i] = 1'b0;
                route_via[i]   = '0;
                route_hops[i]  = '0;
                route_age[i]   = '0;
            end
            awaited_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // track register writes
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_OWN_ID:   self_id         = cfg_data[ID_W-1:0];
                    CFG_NEIGH:    neighbors       = cfg_data[MASK_W-1:0];
                    CFG_INTERVAL: advert_interval = cfg_data[TICK_W-1:0];
                    CFG_TIMEOUT:  route_timeout   = cfg_data[AGE_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                update_routes(in_req);
            if (out_valid && !out_stall)
                match_result(out_result);
            outstanding = awaited_results.size();
        end
    end

endmodule

@@ bench/distance_vector_route_table_test.sv @@
// Top of the route table bench: drives requests, register writes and output stalls,
// and reports the verdict from the checker's mismatch count.
// Depends on dvrt_pkg, distance_vector_route_table and distance_vector_route_table_check.
`timescale 1ns / 1ps

module distance_vector_route_table_test;
    import dvrt_pkg::*;

    // Operation code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    req_t                  in_req;
    logic                  out_valid;
    logic                  out_stall;
    result_t               out_result;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic pace_stall;
    logic hold_stall;
    bit   brisk        = 1'b0;
    bit   hold_request = 1'b0;
    int   mismatches;
    int   outstanding;

    assign out_stall = pace_stall | hold_stall;

    distance_vector_route_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_req       (in_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    distance_vector_route_table_check route_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_req       (in_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // Pace the result side: random stall before each result
    initial
    begin
        int unsigned gap;
        pace_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = brisk ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pace_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            pace_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Hold the result side off for a long stretch once, to back up the block
    initial
    begin
        hold_stall = 1'b0;
        wait (hold_request);
        @(negedge clk);
        hold_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_stall <= 1'b0;
    end

    function automatic req_t request_of(input logic [1:0] op, input logic [ID_W-1:0] sender,
                                        input logic [ID_W-1:0] dest,
                                        input logic [DIST_W-1:0] hops);
        req_t r;
        r.operation           = op;
        r.sender_id           = sender;
        r.dest_id             = dest;
        r.advertised_distance = hops;
        return r;
    endfunction

    // Offer one request after a random gap; return with valid still high
    task automatic offer(input req_t r);
        int unsigned gap;
        gap = brisk ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_req   <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid, wait for every awaited result, then leave the ports idle before returning
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Program all registers, rebuild, then send a random mix of requests
    task automatic run_phase(input logic [ID_W-1:0] own, input logic [MASK_W-1:0] mask,
                             input logic [TICK_W-1:0] interval,
                             input logic [AGE_W-1:0] timeout,
                             input int count, input int tick_pct, input int rebuild_pct);
        logic [ID_W-1:0] sender_pool [4];
        logic [ID_W-1:0] dest_pool   [6];
        int unsigned     roll;
        int              taken;
        req_t            r;
        set_reg(CFG_OWN_ID, CFG_DATA_W'(own));
        set_reg(CFG_NEIGH, CFG_DATA_W'(mask));
        set_reg(CFG_INTERVAL, CFG_DATA_W'(interval));
        set_reg(CFG_TIMEOUT, CFG_DATA_W'(timeout));
        foreach (sender_pool[i])
            sender_pool[i] = ID_W'($urandom_range(0, 31));
        foreach (dest_pool[i])
            dest_pool[i] = ID_W'($urandom_range(0, 31));
        offer(request_of(OP_REBUILD, '0, '0, '0));
        taken = 1;
        while (taken < count)
        begin
            roll = $urandom_range(0, 99);
            // favor a few senders and destinations so routes get revisited
            r.sender_id = ($urandom_range(0, 3) != 0) ? sender_pool[$urandom_range(0, 3)]
                                                      : ID_W'($urandom_range(0, 31));
            r.dest_id   = ($urandom_range(0, 3) != 0) ? dest_pool[$urandom_range(0, 5)]
                                                      : ID_W'($urandom_range(0, 31));
            r.advertised_distance = ($urandom_range(0, 4) == 0) ? DIST_W'($urandom_range(0, 31))
                                                                 : DIST_W'($urandom_range(0, 15));
            if (roll < 3)
                r.operation = OP_UNUSED;
            else if (roll < 3 + rebuild_pct)
                r.operation = OP_REBUILD;
            else if (roll < 3 + rebuild_pct + tick_pct)
                r.operation = OP_TICK;
            else
                r.operation = OP_ADVERT;
            offer(r);
            if (r.operation != OP_UNUSED)
                taken++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_req       = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests under the register reset values
        offer(request_of(OP_REBUILD, 5'd0, 5'd0, 5'd0));
        offer(request_of(OP_ADVERT, 5'd3, 5'd7, 5'd0));     // learn a new route
        offer(request_of(OP_ADVERT, 5'd3, 5'd7, 5'd4));     // same hop, distance grows
        offer(request_of(OP_ADVERT, 5'd3, 5'd7, 5'd4));     // same hop, no change
        offer(request_of(OP_ADVERT, 5'd5, 5'd7, 5'd1));     // shorter path
        offer(request_of(OP_ADVERT, 5'd9, 5'd7, 5'd31));    // unreachable, ignored
        offer(request_of(OP_ADVERT, 5'd5, 5'd7, 5'd16));    // same hop goes unreachable
        offer(request_of(OP_ADVERT, 5'd9, 5'd7, 5'd3));     // recover through another hop
        offer(request_of(OP_ADVERT, 5'd1, 5'd12, 5'd15));   // capped at unreachable, not learned
        offer(request_of(OP_ADVERT, 5'd1, 5'd12, 5'd14));   // learned at distance 15
        offer(request_of(OP_ADVERT, 5'd31, 5'd31, 5'd0));
        offer(request_of(OP_ADVERT, 5'd2, 5'd0, 5'd0));     // own entry, other sender
        offer(request_of(OP_ADVERT, 5'd0, 5'd0, 5'd5));     // own entry, own sender
        offer(request_of(OP_UNUSED, 5'd31, 5'd31, 5'd31));
        repeat (5) offer(request_of(OP_TICK, 5'd0, 5'd0, 5'd0));
        offer(request_of(OP_ADVERT, 5'd31, 5'd31, 5'd31));
        offer(request_of(OP_TICK, 5'd31, 5'd31, 5'd31));
        offer(request_of(OP_REBUILD, 5'd31, 5'd31, 5'd31));
        settle();

        // Full table, advertise and expire on every tick, no idling
        brisk = 1'b1;
        run_phase(5'd31, '1, 8'd1, 8'd1, 25, 25, 4);
        settle();
        brisk        = 1'b0;
        hold_request = 1'b1;
        run_phase(5'd7, $urandom, 8'd3, 8'd4, 50, 25, 4);
        settle();
        // Zero interval and zero timeout
        run_phase(5'd0, '0, 8'd0, 8'd0, 20, 30, 4);
        settle();
        // Long tick run with no rebuild after the first
        run_phase(ID_W'($urandom_range(0, 31)), $urandom, 8'd255, 8'd255, 140, 93, 0);
        settle();
        run_phase(5'd12, $urandom, 8'd2, 8'd15, 40, 30, 4);
        settle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
